### hdl/ffpa_pkg.sv
// Shared types, constants and helpers for the first-fit page allocator.
// Depends on nothing; ffpa_ctrl and the core import it.
package ffpa_pkg;

  localparam int PAGE_COUNT = 16;
  localparam int PAGE_BYTES = 4096;
  localparam int POOL_BYTES = 65536;

  localparam int IDX_W      = $clog2(PAGE_COUNT);
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int REQ_W      = 20;
  localparam int OFF_W      = 21;
  localparam int BYTES_W    = 17;
  localparam int OFFS_W     = 16;
  localparam int STATUS_W   = 3;
  localparam int NEED_W     = REQ_W - PAGE_SHIFT + 1;
  localparam int PGS_W      = BYTES_W - PAGE_SHIFT + 1;
  localparam int ENTRY_W    = 1 + BYTES_W;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NO_RUN    = 3'd1,
    ST_ZERO      = 3'd2,
    ST_OUTSIDE   = 3'd3,
    ST_NOT_START = 3'd4,
    ST_NULL      = 3'd5
  } status_t;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MARK,
    S_FREE_EVAL,
    S_FREE_CLR
  } state_t;

  typedef struct packed {
    logic               used;
    logic [BYTES_W-1:0] bytes;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    status_t            status;
    logic [IDX_W-1:0]   start_page;
    logic [OFFS_W-1:0]  block_offset;
    logic [BYTES_W-1:0] freed_bytes;
  } result_t;

  function automatic result_t make_result(status_t st, logic [IDX_W-1:0] pg,
                                          logic [BYTES_W-1:0] fb);
    result_t r;
    r.status       = st;
    r.start_page   = pg;
    r.block_offset = OFFS_W'(32'(pg) << PAGE_SHIFT);
    r.freed_bytes  = fb;
    return r;
  endfunction

endpackage

### hdl/ffpa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Self-contained; used for the page table of the allocator.
module ffpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hdl/ffpa_ctrl.sv
// Command sequencer of the allocator: clearing pass, first-fit scan,
// marking and freeing passes over the page table. Depends on ffpa_pkg.
module ffpa_ctrl (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic                                cmd,
  input  logic [ffpa_pkg::REQ_W-1:0]          req_bytes,
  input  logic signed [ffpa_pkg::OFF_W-1:0]   free_offset,
  input  logic                                is_null,
  output logic                                busy,
  output logic                                done,
  output ffpa_pkg::result_t                   res,
  output ffpa_pkg::ram_req_t                  ram,
  input  ffpa_pkg::entry_t                    rdata
);
  import ffpa_pkg::*;

  state_t             state, state_next;
  logic [IDX_W:0]     rd_idx, rd_idx_next;
  logic               chk_vld, chk_vld_next;
  logic [IDX_W-1:0]   chk_idx, chk_idx_next;
  logic [IDX_W:0]     run, run_next;
  logic [IDX_W-1:0]   start_pg, start_pg_next;
  logic [NEED_W-1:0]  need, need_next;
  logic [BYTES_W-1:0] req_r, req_r_next;
  logic [IDX_W:0]     cnt, cnt_next;
  logic [PGS_W-1:0]   left, left_next;
  logic [BYTES_W-1:0] size, size_next;
  logic [IDX_W-1:0]   page_r, page_r_next;
  logic               done_next;
  result_t            res_next;

  logic [NEED_W-1:0]  need_in;
  logic [OFF_W-2:0]   off;
  logic [OFF_W-2:0]   off_page;
  logic               outside;
  logic [PGS_W-1:0]   pages;

  assign need_in  = NEED_W'(req_bytes >> PAGE_SHIFT)
                  + NEED_W'(|req_bytes[PAGE_SHIFT-1:0]);
  assign off      = free_offset[OFF_W-2:0];
  assign off_page = off >> PAGE_SHIFT;
  assign outside  = free_offset[OFF_W-1] || (32'(off) >= POOL_BYTES)
                 || (32'(off_page) >= PAGE_COUNT);
  assign pages    = PGS_W'(rdata.bytes >> PAGE_SHIFT)
                  + PGS_W'(|rdata.bytes[PAGE_SHIFT-1:0]);
  assign busy     = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      done  <= done_next;
    end
    rd_idx   <= rd_idx_next;
    chk_vld  <= chk_vld_next;
    chk_idx  <= chk_idx_next;
    run      <= run_next;
    start_pg <= start_pg_next;
    need     <= need_next;
    req_r    <= req_r_next;
    left     <= left_next;
    size     <= size_next;
    page_r   <= page_r_next;
    res      <= res_next;
  end

  always_comb begin
    logic [IDX_W:0] run_inc;
    run_inc       = run + 1'b1;
    state_next    = state;
    rd_idx_next   = rd_idx;
    chk_vld_next  = chk_vld;
    chk_idx_next  = chk_idx;
    run_next      = run;
    start_pg_next = start_pg;
    need_next     = need;
    req_r_next    = req_r;
    cnt_next      = cnt;
    left_next     = left;
    size_next     = size;
    page_r_next   = page_r;
    done_next     = 1'b0;
    res_next      = res;
    ram           = '0;

    unique case (state)
      S_CLEAR: begin
        ram.we    = 1'b1;
        ram.waddr = cnt[IDX_W-1:0];
        cnt_next  = cnt + 1'b1;
        if (cnt[IDX_W-1:0] == IDX_W'(PAGE_COUNT - 1)) begin
          state_next = S_IDLE;
        end
      end

      S_IDLE: begin
        if (start) begin
          if (cmd == CMD_FREE) begin
            if (is_null) begin
              res_next  = make_result(ST_NULL, '0, '0);
              done_next = 1'b1;
            end else if (outside) begin
              res_next  = make_result(ST_OUTSIDE, '0, '0);
              done_next = 1'b1;
            end else begin
              ram.raddr   = off_page[IDX_W-1:0];
              page_r_next = off_page[IDX_W-1:0];
              state_next  = S_FREE_EVAL;
            end
          end else begin
            if (req_bytes == '0) begin
              res_next  = make_result(ST_ZERO, '0, '0);
              done_next = 1'b1;
            end else if (32'(need_in) > PAGE_COUNT) begin
              res_next  = make_result(ST_NO_RUN, '0, '0);
              done_next = 1'b1;
            end else begin
              need_next    = need_in;
              req_r_next   = req_bytes[BYTES_W-1:0];
              rd_idx_next  = '0;
              chk_vld_next = 1'b0;
              run_next     = '0;
              state_next   = S_SCAN;
            end
          end
        end
      end

      S_SCAN: begin
        // Reads run one page ahead of the evaluation of the returned word.
        ram.raddr = rd_idx[IDX_W-1:0];
        if (32'(rd_idx) < PAGE_COUNT) begin
          rd_idx_next  = rd_idx + 1'b1;
          chk_vld_next = 1'b1;
          chk_idx_next = rd_idx[IDX_W-1:0];
        end else begin
          chk_vld_next = 1'b0;
        end
        if (chk_vld) begin
          if (!rdata.used) begin
            run_next = run_inc;
            if (run == '0) begin
              start_pg_next = chk_idx;
            end
            if (NEED_W'(run_inc) == need) begin
              cnt_next   = '0;
              state_next = S_MARK;
            end else if (chk_idx == IDX_W'(PAGE_COUNT - 1)) begin
              res_next   = make_result(ST_NO_RUN, '0, '0);
              done_next  = 1'b1;
              state_next = S_IDLE;
            end
          end else begin
            run_next = '0;
            if (chk_idx == IDX_W'(PAGE_COUNT - 1)) begin
              res_next   = make_result(ST_NO_RUN, '0, '0);
              done_next  = 1'b1;
              state_next = S_IDLE;
            end
          end
        end
      end

      S_MARK: begin
        ram.we         = 1'b1;
        ram.waddr      = start_pg + cnt[IDX_W-1:0];
        ram.wdata.used = 1'b1;
        ram.wdata.bytes = (cnt == '0) ? req_r : '0;
        cnt_next       = cnt + 1'b1;
        if (NEED_W'(cnt) + 1'b1 == need) begin
          res_next   = make_result(ST_OK, start_pg, '0);
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_FREE_EVAL: begin
        if (!rdata.used || rdata.bytes == '0) begin
          res_next   = make_result(ST_NOT_START, '0, '0);
          done_next  = 1'b1;
          state_next = S_IDLE;
        end else begin
          size_next  = rdata.bytes;
          left_next  = pages;
          cnt_next   = {1'b0, page_r};
          state_next = S_FREE_CLR;
        end
      end

      S_FREE_CLR: begin
        // Clearing stops early at the last page of the pool.
        ram.we    = 1'b1;
        ram.waddr = cnt[IDX_W-1:0];
        cnt_next  = cnt + 1'b1;
        left_next = left - 1'b1;
        if (left == PGS_W'(1) || cnt[IDX_W-1:0] == IDX_W'(PAGE_COUNT - 1)) begin
          res_next   = make_result(ST_OK, page_r, size);
          done_next  = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### hdl/first_fit_page_allocator_core.sv
// First-fit contiguous page allocator over a pool of 16 pages of 4 KB.
//
// Commands enter on start while busy is low: cmd selects allocate or free,
// req_bytes carries the size for an allocate, free_offset and is_null the
// pointer for a free. Each command gives one result word on status,
// start_page, block_offset and freed_bytes, shown for exactly one cycle
// with done high; the receiver cannot hold it off.
// Zero size, oversized, null and out-of-pool commands answer straight from the
// idle state. An allocate scans the page table one page a cycle through the
// table's registered read port until a run is found, then writes one page a
// cycle to mark it; a failed scan answers after the last page. A free reads
// the entry of its page and answers with a not-start status when the page
// does not start a block; else it clears one page a cycle. busy stays high
// until done is raised, and a new command may be given in the cycle that
// done is high.
// After reset a clearing pass writes every entry of the page table, one a
// cycle, and busy is high until it ends.
// Depends on ffpa_pkg, ffpa_ctrl and ffpa_ram.
module first_fit_page_allocator_core (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic                                   cmd,
  input  logic [ffpa_pkg::REQ_W-1:0]             req_bytes,
  input  logic signed [ffpa_pkg::OFF_W-1:0]      free_offset,
  input  logic                                   is_null,
  output logic                                   done,
  output logic [ffpa_pkg::STATUS_W-1:0]          status,
  output logic [ffpa_pkg::IDX_W-1:0]             start_page,
  output logic [ffpa_pkg::OFFS_W-1:0]            block_offset,
  output logic [ffpa_pkg::BYTES_W-1:0]           freed_bytes
);
  import ffpa_pkg::*;

  ram_req_t ram;
  entry_t   rdata;
  result_t  res;

  ffpa_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .cmd         (cmd),
    .req_bytes   (req_bytes),
    .free_offset (free_offset),
    .is_null     (is_null),
    .busy        (busy),
    .done        (done),
    .res         (res),
    .ram         (ram),
    .rdata       (rdata)
  );

  ffpa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PAGE_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (ram.we),
    .waddr (ram.waddr),
    .wdata (ram.wdata),
    .raddr (ram.raddr),
    .rdata (rdata)
  );

  assign status       = res.status;
  assign start_page   = res.start_page;
  assign block_offset = res.block_offset;
  assign freed_bytes  = res.freed_bytes;

endmodule
